// ===== hw/rtl/clrp_pkg.sv =====
// ----------------------------------------------------------------------------
// clrp_pkg: shared types and constants of the commit log record parser
// Holds the channel payload structs, the parser phase enum, the verdict codes
// and the job format carried from the parsing front to the output back end.
// ----------------------------------------------------------------------------
package clrp_pkg;

  // Register indexes on the configuration port.
  localparam logic CfgMagicWord     = 1'b0;
  localparam logic CfgFormatVersion = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [31:0] MagicWordReset     = 32'h0000_0000;
  localparam logic [31:0] FormatVersionReset = 32'h0000_0001;

  // Largest legal status code in a record.
  localparam logic [7:0] MaxStatus = 8'd3;

  // Result kinds.
  localparam logic KindRecord  = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // Verdict codes.
  localparam logic [2:0] VerdictOk      = 3'd0;
  localparam logic [2:0] VerdictShort   = 3'd1;
  localparam logic [2:0] VerdictMagic   = 3'd2;
  localparam logic [2:0] VerdictVersion = 3'd3;
  localparam logic [2:0] VerdictTrunc   = 3'd4;
  localparam logic [2:0] VerdictStatus  = 3'd5;
  localparam logic [2:0] VerdictTrail   = 3'd6;

  // Byte position of the last byte of a little-endian u32.
  localparam logic [1:0] WordLastByte = 2'd3;

  typedef enum logic [2:0] {
    PhaseMagic,
    PhaseVersion,
    PhaseCount,
    PhaseId,
    PhaseStatus,
    PhaseTail
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] txn_id;
    logic [1:0]  txn_status;
    logic [2:0]  verdict;
    logic        last_of_run;
  } out_item_t;

  // All results caused by one input byte: an optional record followed by
  // an optional verdict.
  typedef struct packed {
    logic        has_record;
    logic [31:0] txn_id;
    logic [1:0]  txn_status;
    logic        has_verdict;
    logic [2:0]  verdict;
  } job_t;

endpackage

// ===== hw/rtl/clrp_front.sv =====
// ----------------------------------------------------------------------------
// clrp_front: byte parser
// Holds the configuration registers and the header/record parsing state, and
// turns each accepted byte into at most one job for the result queue.
// ----------------------------------------------------------------------------
module clrp_front #(
  parameter int MAGIC_BYTES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               accept_i,
  input  clrp_pkg::in_item_t item_i,
  output logic               job_valid_o,
  output clrp_pkg::job_t     job_o
);

  localparam logic [1:0] MagicLast = 2'(MAGIC_BYTES - 1);

  logic [31:0]      magic_q, version_q;
  clrp_pkg::phase_e phase_q, phase_d;
  logic [1:0]       pos_q, pos_d;
  logic [31:0]      asm_q, asm_d;
  logic [31:0]      left_q, left_d;
  logic             drop_q, drop_d;
  logic             hbad_q, hbad_d;
  logic [2:0]       hcode_q, hcode_d;

  logic [31:0]      gathered;
  logic [7:0]       want;
  logic             close_en, start_en;
  logic [2:0]       close_code;
  logic [7:0]       b;
  logic             last;

  assign b        = item_i.data_byte;
  assign last     = item_i.end_of_buffer;
  assign want     = magic_q[{pos_q, 3'b000} +: 8];
  assign gathered = asm_q | ({24'h000000, b} << {pos_q, 3'b000});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= clrp_pkg::MagicWordReset;
      version_q <= clrp_pkg::FormatVersionReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        clrp_pkg::CfgMagicWord:     magic_q   <= cfg_data_i;
        clrp_pkg::CfgFormatVersion: version_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= clrp_pkg::PhaseMagic;
      pos_q   <= 2'd0;
      asm_q   <= 32'd0;
      left_q  <= 32'd0;
      drop_q  <= 1'b0;
      hbad_q  <= 1'b0;
      hcode_q <= clrp_pkg::VerdictOk;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      asm_q   <= asm_d;
      left_q  <= left_d;
      drop_q  <= drop_d;
      hbad_q  <= hbad_d;
      hcode_q <= hcode_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    asm_d       = asm_q;
    left_d      = left_q;
    drop_d      = drop_q;
    hbad_d      = hbad_q;
    hcode_d     = hcode_q;
    close_en    = 1'b0;
    close_code  = clrp_pkg::VerdictOk;
    start_en    = 1'b0;
    job_o       = '0;
    if (accept_i) begin
      if (drop_q) begin
        start_en = last;
      end else begin
        unique case (phase_q)
          clrp_pkg::PhaseMagic: begin
            if (b != want && !hbad_q) begin
              hbad_d  = 1'b1;
              hcode_d = clrp_pkg::VerdictMagic;
            end
            if (pos_q == MagicLast) begin
              phase_d = clrp_pkg::PhaseVersion;
              pos_d   = 2'd0;
              asm_d   = 32'd0;
            end else begin
              pos_d = pos_q + 2'd1;
            end
            if (last) begin
              close_en   = 1'b1;
              close_code = clrp_pkg::VerdictShort;
            end
          end
          clrp_pkg::PhaseVersion: begin
            if (pos_q == clrp_pkg::WordLastByte) begin
              if (gathered != version_q && !hbad_q) begin
                hbad_d  = 1'b1;
                hcode_d = clrp_pkg::VerdictVersion;
              end
              phase_d = clrp_pkg::PhaseCount;
              pos_d   = 2'd0;
              asm_d   = 32'd0;
            end else begin
              asm_d = gathered;
              pos_d = pos_q + 2'd1;
            end
            if (last) begin
              close_en   = 1'b1;
              close_code = clrp_pkg::VerdictShort;
            end
          end
          clrp_pkg::PhaseCount: begin
            if (pos_q != clrp_pkg::WordLastByte) begin
              asm_d = gathered;
              pos_d = pos_q + 2'd1;
              if (last) begin
                close_en   = 1'b1;
                close_code = clrp_pkg::VerdictShort;
              end
            end else if (hbad_q) begin
              close_en   = 1'b1;
              close_code = hcode_q;
            end else begin
              left_d  = gathered;
              pos_d   = 2'd0;
              asm_d   = 32'd0;
              phase_d = (gathered != 32'd0) ? clrp_pkg::PhaseId : clrp_pkg::PhaseTail;
              if (last) begin
                close_en   = 1'b1;
                close_code = (gathered == 32'd0) ? clrp_pkg::VerdictOk
                                                 : clrp_pkg::VerdictTrunc;
              end
            end
          end
          clrp_pkg::PhaseId: begin
            asm_d = gathered;
            if (pos_q == clrp_pkg::WordLastByte) begin
              phase_d = clrp_pkg::PhaseStatus;
              pos_d   = 2'd0;
            end else begin
              pos_d = pos_q + 2'd1;
            end
            if (last) begin
              close_en   = 1'b1;
              close_code = clrp_pkg::VerdictTrunc;
            end
          end
          clrp_pkg::PhaseStatus: begin
            if (b > clrp_pkg::MaxStatus) begin
              close_en   = 1'b1;
              close_code = clrp_pkg::VerdictStatus;
            end else begin
              job_o.has_record = 1'b1;
              job_o.txn_id     = asm_q;
              job_o.txn_status = b[1:0];
              left_d  = left_q - 32'd1;
              asm_d   = 32'd0;
              pos_d   = 2'd0;
              phase_d = (left_q != 32'd1) ? clrp_pkg::PhaseId : clrp_pkg::PhaseTail;
              if (last) begin
                close_en   = 1'b1;
                close_code = (left_q == 32'd1) ? clrp_pkg::VerdictOk
                                               : clrp_pkg::VerdictTrunc;
              end
            end
          end
          default: begin
            close_en   = 1'b1;
            close_code = clrp_pkg::VerdictTrail;
          end
        endcase
        if (close_en) begin
          job_o.has_verdict = 1'b1;
          job_o.verdict     = close_code;
          if (last) begin
            start_en = 1'b1;
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      if (start_en) begin
        phase_d = clrp_pkg::PhaseMagic;
        pos_d   = 2'd0;
        asm_d   = 32'd0;
        left_d  = 32'd0;
        drop_d  = 1'b0;
        hbad_d  = 1'b0;
        hcode_d = clrp_pkg::VerdictOk;
      end
    end
    job_valid_o = accept_i && (job_o.has_record || job_o.has_verdict);
  end

endmodule

// ===== hw/rtl/clrp_queue.sv =====
// ----------------------------------------------------------------------------
// clrp_queue: two-entry job queue
// Decouples the parser from the output stage; push and pop may coincide.
// ----------------------------------------------------------------------------
module clrp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clrp_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output clrp_pkg::job_t head_o
);

  clrp_pkg::job_t slot_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/clrp_back.sv =====
// ----------------------------------------------------------------------------
// clrp_back: result sequencer
// Expands the job at the queue head into one or two result transfers.
// ----------------------------------------------------------------------------
module clrp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  clrp_pkg::job_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clrp_pkg::out_item_t out_item_o
);

  // Set once the record part of a two-result job has been transferred.
  logic rec_done_q, rec_done_d;
  logic send_rec;
  logic xfer;

  assign out_valid_o = !empty_i;
  assign xfer        = out_valid_o && out_ready_i;
  assign send_rec    = head_i.has_record && !rec_done_q;

  always_comb begin
    out_item_o = '0;
    if (send_rec) begin
      out_item_o.item_kind   = clrp_pkg::KindRecord;
      out_item_o.txn_id      = head_i.txn_id;
      out_item_o.txn_status  = head_i.txn_status;
      out_item_o.last_of_run = !head_i.has_verdict;
    end else begin
      out_item_o.item_kind   = clrp_pkg::KindVerdict;
      out_item_o.verdict     = head_i.verdict;
      out_item_o.last_of_run = 1'b1;
    end
    pop_o      = xfer && !(send_rec && head_i.has_verdict);
    rec_done_d = rec_done_q;
    if (xfer) begin
      rec_done_d = send_rec && head_i.has_verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_done_q <= 1'b0;
    end else begin
      rec_done_q <= rec_done_d;
    end
  end

endmodule

// ===== hw/rtl/commit_log_record_parser.sv =====
// ----------------------------------------------------------------------------
// commit_log_record_parser: byte-serial transaction status log parser
// Checks a log buffer header against the magic and version registers, emits
// each valid record as it completes and closes every buffer with a verdict.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  ------------------------------------
//   input     in_valid_i / in_ready_o    in_item_i  (data_byte, end_of_buffer)
//   output    out_valid_o / out_ready_i  out_item_o (kind, id, status, verdict,
//                                                   last_of_run)
//   config    cfg_we_i                   cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while the job queue has room. A byte's results
// are registered in a two-entry job queue before they reach the output port.
// A byte that closes a buffer with a record and a verdict needs two output
// transfers. The queue lets the input keep transferring while the output
// stalls, until both entries are taken. Reset is asynchronous and clears
// parser state and the queue; the registers return to magic 0 and version 1.
//
module commit_log_record_parser #(
  parameter int MAGIC_BYTES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  clrp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clrp_pkg::out_item_t out_item_o
);

  logic           accept;
  logic           job_valid;
  clrp_pkg::job_t job;
  logic           q_full, q_empty, q_pop;
  clrp_pkg::job_t q_head;

  // A byte is taken whenever the queue has room for the job it may create.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // The front parses bytes and builds jobs; the register bank lives here too.
  clrp_front #(
    .MAGIC_BYTES (MAGIC_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  clrp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_valid),
    .push_job_i (job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  // The back end turns each job into its record and verdict transfers.
  clrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hw/rtl/clrp_checker.sv =====
// ----------------------------------------------------------------------------
// clrp_checker: port-level assertions for the log record parser
// Watches the output channel for stable stalls and well-formed results.
// ----------------------------------------------------------------------------
module clrp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input clrp_pkg::out_item_t out_item_o
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("output payload changed while stalled");

  a_verdict_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.item_kind == clrp_pkg::KindVerdict |->
      out_item_o.last_of_run && out_item_o.txn_id == 32'd0
      && out_item_o.txn_status == 2'd0 && out_item_o.verdict != 3'd7)
    else $error("malformed verdict transfer");

  a_record_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.item_kind == clrp_pkg::KindRecord |->
      out_item_o.verdict == clrp_pkg::VerdictOk)
    else $error("record transfer carries a verdict code");

  a_record_then_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.item_kind == clrp_pkg::KindRecord
      && !out_item_o.last_of_run |=>
      out_valid_o && out_item_o.item_kind == clrp_pkg::KindVerdict)
    else $error("record not followed by its verdict");

endmodule

bind commit_log_record_parser clrp_checker u_clrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
